[hdl/nearest_neighbor_tour_top_assert.svh]
// Assertion macros for the nearest-neighbour tour block.
// Included by the top level; needs nothing else.
`ifndef NEAREST_NEIGHBOR_TOUR_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_TOUR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define NNT_ASSERT_IMP(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define NNT_ASSERT_NXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/nnt_pkg.sv]
// Shared types and constants of the nearest-neighbour tour block.
// No dependencies.
package nnt_pkg;

  localparam int CITY_W  = 5;   // city index field
  localparam int CNT_W   = 6;   // city count, holds 32
  localparam int FIELD_W = 16;  // coordinate field on the input channel

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_CITY_COUNT = 1'b0;
  localparam logic [CNT_W-1:0] CITY_COUNT_RESET = 6'd32;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  // control of the shared distance unit
  typedef struct packed {
    logic diff_en;  // latch candidate and absolute differences
    logic sqx_en;   // square dx
    logic sqy_en;   // square dy
  } nnt_dist_ctl_t;

endpackage

[hdl/nnt_in_if.sv]
// Input channel of the nearest-neighbour tour block: load and run beats.
// Depends on nnt_pkg for field widths.
interface nnt_in_if import nnt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic [CITY_W-1:0]        city_index;
  logic signed [FIELD_W-1:0] coord_x;
  logic signed [FIELD_W-1:0] coord_y;
  logic [CITY_W-1:0]        start_city;

  modport source (output valid, kind, city_index, coord_x, coord_y, start_city,
                  input ready);
  modport sink (input valid, kind, city_index, coord_x, coord_y, start_city,
                output ready);
endinterface

[hdl/nnt_out_if.sv]
// Output channel of the nearest-neighbour tour block: one city per beat.
// Depends on nnt_pkg for field widths.
interface nnt_out_if import nnt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CITY_W-1:0] tour_city;
  logic              is_last;

  modport source (output valid, tour_city, is_last, input ready);
  modport sink (input valid, tour_city, is_last, output ready);
endinterface

[hdl/nnt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nnt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/nnt_dist_unit.sv]
// Squared-distance unit: absolute differences, one shared squarer, final sum.
// Depends on nnt_pkg for the control struct.
module nnt_dist_unit import nnt_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  nnt_dist_ctl_t                ctl_i,
  input  logic signed [COORD_BITS-1:0] cur_x_i,
  input  logic signed [COORD_BITS-1:0] cur_y_i,
  input  logic signed [COORD_BITS-1:0] cand_x_i,
  input  logic signed [COORD_BITS-1:0] cand_y_i,
  output logic signed [COORD_BITS-1:0] cand_x_o,
  output logic signed [COORD_BITS-1:0] cand_y_o,
  output logic [2*COORD_BITS:0]        dist_o
);

  localparam int CB = COORD_BITS;

  logic signed [CB:0] diff_x, diff_y;
  logic [CB-1:0]      abs_x, abs_y;
  logic [CB-1:0]      dx_q, dy_q;
  logic [CB-1:0]      op;
  logic [2*CB-1:0]    prod;
  logic [2*CB-1:0]    sqx_q, sqy_q;

  always_comb begin
    diff_x = {cand_x_i[CB-1], cand_x_i} - {cur_x_i[CB-1], cur_x_i};
    diff_y = {cand_y_i[CB-1], cand_y_i} - {cur_y_i[CB-1], cur_y_i};
    abs_x  = diff_x[CB] ? CB'(-diff_x) : diff_x[CB-1:0];
    abs_y  = diff_y[CB] ? CB'(-diff_y) : diff_y[CB-1:0];
  end

  // one squarer serves both axes
  assign op   = ctl_i.sqy_en ? dy_q : dx_q;
  assign prod = {{CB{1'b0}}, op} * {{CB{1'b0}}, op};

  always_ff @(posedge clk_i) begin
    if (ctl_i.diff_en) begin
      dx_q     <= abs_x;
      dy_q     <= abs_y;
      cand_x_o <= cand_x_i;
      cand_y_o <= cand_y_i;
    end
    if (ctl_i.sqx_en) begin
      sqx_q <= prod;
    end
    if (ctl_i.sqy_en) begin
      sqy_q <= prod;
    end
  end

  assign dist_o = {1'b0, sqx_q} + {1'b0, sqy_q};

endmodule

[hdl/nearest_neighbor_tour_top.sv]
// Nearest-neighbour tour builder: input item channel, tour city output channel.
//
// Usage:
//   in_i carries load beats (kind 0: city_index, coord_x, coord_y) and run
//   beats (kind 1: start_city). A load writes one city.
//   A run emits n + 1 beats on out_o, n being city_count clamped to 2..32:
//   the start city, each nearest unvisited city in turn (ties to the lower
//   index), then the start city again with is_last set. A run whose start is
//   not below n emits nothing.
//   Each step of a run scans all cities in use. An unvisited candidate
//   passes through the difference, square-x, square-y and compare states,
//   the two square states sharing one squarer; a visited one is skipped.
//   in_i.ready is high only between runs; a finished beat in the output
//   register does not block the next item. When out_o is stalled the
//   sequencer holds at its next beat until the register drains.
//   city_count is to be written over the APB port between items; the block
//   does not enforce this. Reset clears control state and sets city_count
//   to 32; city coordinates stay undefined until loaded.
// Depends on nnt_pkg, nnt_in_if, nnt_out_if, nnt_ram, nnt_dist_unit and
// nearest_neighbor_tour_top_assert.svh.
`include "nearest_neighbor_tour_top_assert.svh"

module nearest_neighbor_tour_top import nnt_pkg::*; #(
  parameter int MAX_CITIES = 32,
  parameter int COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nnt_in_if.sink            in_i,
  nnt_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CITY_LIMIT = (MAX_CITIES < 32) ? MAX_CITIES : 32;
  localparam int AW = $clog2(CITY_LIMIT);
  localparam int CB = COORD_BITS;
  localparam int DW = 2 * CB + 1;
  localparam logic [CNT_W-1:0] LIMIT_CNT = CNT_W'(CITY_LIMIT);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CUR  = 3'd1;
  localparam logic [2:0] S_EMIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DIFF = 3'd4;
  localparam logic [2:0] S_SQX  = 3'd5;
  localparam logic [2:0] S_SQY  = 3'd6;
  localparam logic [2:0] S_CMP  = 3'd7;

  // configuration
  logic [CNT_W-1:0] city_count_q;
  logic [CNT_W-1:0] n_eff;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CITY_COUNT) ? APB_DW'(city_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CITY_COUNT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_CITY_COUNT) begin
      city_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (city_count_q < CNT_W'(2)) begin
      n_eff = CNT_W'(2);
    end else if (city_count_q > LIMIT_CNT) begin
      n_eff = LIMIT_CNT;
    end else begin
      n_eff = city_count_q;
    end
  end

  // coordinate conversion to COORD_BITS
  logic [CB-1:0] x_raw, y_raw;

  generate
    if (CB <= FIELD_W) begin : g_narrow
      assign x_raw = in_i.coord_x[CB-1:0];
      assign y_raw = in_i.coord_y[CB-1:0];
    end else begin : g_wide
      assign x_raw = {{(CB-FIELD_W){1'b0}}, in_i.coord_x};
      assign y_raw = {{(CB-FIELD_W){1'b0}}, in_i.coord_y};
    end
  endgenerate

  // sequencer state
  logic [2:0]            state_q, state_d;
  logic [CITY_LIMIT-1:0] visited_q, visited_d;
  logic [CNT_W-1:0]      vcount_q, vcount_d;
  logic [CNT_W-1:0]      idx_q, idx_d;
  logic                  found_q, found_d;
  logic [CITY_W-1:0]     start_q, start_d;
  logic [CITY_W-1:0]     emit_city_q, emit_city_d;
  logic                  emit_last_q, emit_last_d;
  logic [CITY_W-1:0]     best_q, best_d;
  logic [DW-1:0]         best_dist_q, best_dist_d;
  logic signed [CB-1:0]  best_x_q, best_x_d, best_y_q, best_y_d;
  logic signed [CB-1:0]  cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                  out_valid_q, out_valid_d;
  logic [CITY_W-1:0]     out_city_q, out_city_d;
  logic                  out_last_q, out_last_d;

  logic                  in_acc, out_slot, push, commit;
  logic                  ram_we;
  logic [AW-1:0]         ram_raddr;
  logic [2*CB-1:0]       ram_rdata;
  logic signed [CB-1:0]  rd_x, rd_y, cand_x, cand_y;
  logic [DW-1:0]         cand_dist;
  nnt_dist_ctl_t         dctl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_slot   = !out_valid_q || out_o.ready;
  assign push       = (state_q == S_EMIT) && out_slot;
  assign commit     = (state_q == S_SCAN) && (idx_q == n_eff);

  assign ram_we = in_acc && (in_i.kind == KIND_LOAD) &&
                  ({1'b0, in_i.city_index} < LIMIT_CNT);
  assign ram_raddr = (state_q == S_IDLE) ? in_i.start_city[AW-1:0] : idx_q[AW-1:0];
  assign rd_x = ram_rdata[2*CB-1:CB];
  assign rd_y = ram_rdata[CB-1:0];

  nnt_ram #(
    .WIDTH (2 * CB),
    .DEPTH (CITY_LIMIT)
  ) u_coord_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.city_index[AW-1:0]),
    .wdata_i ({x_raw, y_raw}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign dctl.diff_en = (state_q == S_DIFF);
  assign dctl.sqx_en  = (state_q == S_SQX);
  assign dctl.sqy_en  = (state_q == S_SQY);

  nnt_dist_unit #(
    .COORD_BITS (CB)
  ) u_dist (
    .clk_i    (clk_i),
    .ctl_i    (dctl),
    .cur_x_i  (cur_x_q),
    .cur_y_i  (cur_y_q),
    .cand_x_i (rd_x),
    .cand_y_i (rd_y),
    .cand_x_o (cand_x),
    .cand_y_o (cand_y),
    .dist_o   (cand_dist)
  );

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    vcount_d    = vcount_q;
    idx_d       = idx_q;
    found_d     = found_q;
    start_d     = start_q;
    emit_city_d = emit_city_q;
    emit_last_d = emit_last_q;
    best_d      = best_q;
    best_dist_d = best_dist_q;
    best_x_d    = best_x_q;
    best_y_d    = best_y_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    out_city_d  = out_city_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_o.ready;

    case (state_q)
      S_IDLE: begin
        if (in_acc && in_i.kind == KIND_RUN && {1'b0, in_i.start_city} < n_eff) begin
          start_d   = in_i.start_city;
          visited_d = '0;
          visited_d[in_i.start_city[AW-1:0]] = 1'b1;
          vcount_d  = CNT_W'(1);
          state_d   = S_CUR;
        end
      end
      S_CUR: begin
        cur_x_d     = rd_x;
        cur_y_d     = rd_y;
        emit_city_d = start_q;
        emit_last_d = 1'b0;
        state_d     = S_EMIT;
      end
      S_EMIT: begin
        if (out_slot) begin
          out_valid_d = 1'b1;
          out_city_d  = emit_city_q;
          out_last_d  = emit_last_q;
          if (emit_last_q) begin
            state_d = S_IDLE;
          end else if (vcount_q == n_eff) begin
            // every city visited: close the tour
            emit_city_d = start_q;
            emit_last_d = 1'b1;
          end else begin
            idx_d   = '0;
            found_d = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (commit) begin
          visited_d[best_q[AW-1:0]] = 1'b1;
          vcount_d    = vcount_q + CNT_W'(1);
          cur_x_d     = best_x_q;
          cur_y_d     = best_y_q;
          emit_city_d = best_q;
          emit_last_d = 1'b0;
          state_d     = S_EMIT;
        end else if (visited_q[idx_q[AW-1:0]]) begin
          idx_d = idx_q + CNT_W'(1);
        end else begin
          state_d = S_DIFF;
        end
      end
      S_DIFF: state_d = S_SQX;
      S_SQX:  state_d = S_SQY;
      S_SQY:  state_d = S_CMP;
      S_CMP: begin
        // strict compare keeps the lower index on a tie
        if (!found_q || cand_dist < best_dist_q) begin
          found_d     = 1'b1;
          best_d      = idx_q[CITY_W-1:0];
          best_dist_d = cand_dist;
          best_x_d    = cand_x;
          best_y_d    = cand_y;
        end
        idx_d   = idx_q + CNT_W'(1);
        state_d = S_SCAN;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      visited_q   <= '0;
      vcount_q    <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      visited_q   <= visited_d;
      vcount_q    <= vcount_d;
      idx_q       <= idx_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q     <= start_d;
    emit_city_q <= emit_city_d;
    emit_last_q <= emit_last_d;
    best_q      <= best_d;
    best_dist_q <= best_dist_d;
    best_x_q    <= best_x_d;
    best_y_q    <= best_y_d;
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    out_city_q  <= out_city_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.tour_city = out_city_q;
  assign out_o.is_last   = out_last_q;

  `NNT_ASSERT_IMP(a_count_matches_mask, clk_i, rst_ni, 1'b1,
    $countones(visited_q) == int'(vcount_q), "visited count out of step with mask")
  `NNT_ASSERT_IMP(a_count_bounded, clk_i, rst_ni, state_q != S_IDLE,
    vcount_q <= n_eff, "visited count beyond city count")
  `NNT_ASSERT_IMP(a_commit_has_best, clk_i, rst_ni, commit,
    found_q && !visited_q[best_q[AW-1:0]], "scan ended without an unvisited best")
  `NNT_ASSERT_IMP(a_last_when_full, clk_i, rst_ni, push && emit_last_q,
    vcount_q == n_eff, "tour closed before all cities visited")
  `NNT_ASSERT_NXT(a_commit_emits, clk_i, rst_ni, commit,
    state_q == S_EMIT && emit_city_q == $past(best_q), "chosen city not queued")

endmodule
